// ----- design/fuzzy_threshold_inference_core_assert.svh -----
// Assertion macros shared by the fuzzy threshold inference design
`ifndef FUZZY_THRESHOLD_INFERENCE_CORE_ASSERT_SVH
`define FUZZY_THRESHOLD_INFERENCE_CORE_ASSERT_SVH

// expression holds at every clock edge outside reset
`define FTI_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: label");

// consequent holds in the same cycle as the antecedent
`define FTI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// consequent holds in the cycle after the antecedent
`define FTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ----- design/fti_pkg.sv -----
// Shared types, constants and register codes of the fuzzy threshold inference core
package fti_pkg;

  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam int WEIGHT_W  = 16;
  localparam int LIMIT_W   = 17;
  localparam int SIZE_W    = 16;
  localparam int PAT_W     = 2;
  localparam int LOAD_W    = 10;
  localparam int BW_W      = 17;
  localparam int RESULT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  localparam int QUOT_BITS   = 16;
  localparam int COG_LAT     = QUOT_BITS + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RESULT_W-1:0] COG_MAX = 16'd58982;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_W_DELTA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_W_DELTA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_W_LAMBDA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_W_LAMBDA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_W_LAMBDA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BW_W_LAMBDA   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BW_LOW        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BW_HIGH       = 3'd7;

  localparam logic [WEIGHT_W-1:0] RST_SIZE_W_DELTA  = 16'd32768;
  localparam logic [WEIGHT_W-1:0] RST_PAT_W_DELTA   = 16'd32768;
  localparam logic [WEIGHT_W-1:0] RST_SIZE_W_LAMBDA = 16'd13107;
  localparam logic [WEIGHT_W-1:0] RST_PAT_W_LAMBDA  = 16'd19661;
  localparam logic [WEIGHT_W-1:0] RST_LOAD_W_LAMBDA = 16'd19661;
  localparam logic [WEIGHT_W-1:0] RST_BW_W_LAMBDA   = 16'd13107;
  localparam logic [LIMIT_W-1:0]  RST_BW_LOW        = 17'd55;
  localparam logic [LIMIT_W-1:0]  RST_BW_HIGH       = 17'd550;

  localparam logic [PAT_W-1:0] PAT_MS = 2'd0;
  localparam logic [PAT_W-1:0] PAT_AA = 2'd1;

  localparam logic [1:0] LEVEL_LO  = 2'd0;
  localparam logic [1:0] LEVEL_MID = 2'd1;
  localparam logic [1:0] LEVEL_HI  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_B1 = 16'd14;
  localparam logic [SIZE_W-1:0] SIZE_B2 = 16'd28;
  localparam logic [SIZE_W-1:0] SIZE_B3 = 16'd42;
  localparam logic [SIZE_W-1:0] SIZE_B4 = 16'd56;
  localparam int SIZE_SPAN  = 14;
  localparam int SIZE_IDX_W = $clog2(SIZE_SPAN);

  localparam logic [LOAD_W-1:0] LOAD_B1  = 10'd200;
  localparam logic [LOAD_W-1:0] LOAD_B2  = 10'd400;
  localparam logic [LOAD_W-1:0] LOAD_B3  = 10'd600;
  localparam logic [LOAD_W-1:0] LOAD_B4  = 10'd800;
  localparam logic [LOAD_W-1:0] LOAD_MAX = 10'd1000;
  localparam int LOAD_SPAN  = 200;
  localparam int LOAD_IDX_W = $clog2(LOAD_SPAN);

  typedef struct packed {
    logic [WEIGHT_W-1:0] size_w_delta;
    logic [WEIGHT_W-1:0] pat_w_delta;
    logic [WEIGHT_W-1:0] size_w_lambda;
    logic [WEIGHT_W-1:0] pat_w_lambda;
    logic [WEIGHT_W-1:0] load_w_lambda;
    logic [WEIGHT_W-1:0] bw_w_lambda;
    logic [LIMIT_W-1:0]  bw_low;
    logic [LIMIT_W-1:0]  bw_high;
  } cfg_t;

  typedef struct packed {
    logic       err;
    logic       aa;
    logic [1:0] size_lvl;
    logic [1:0] load_lvl;
    logic [1:0] band;
  } cls_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- design/fti_front.sv -----
// Front end: accepts a request and classifies size, load, bandwidth and pattern
module fti_front #(
  parameter int FRACTION_BITS = fti_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [fti_pkg::SIZE_W-1:0]  request_size,
  input  logic [fti_pkg::PAT_W-1:0]   traffic_pattern,
  input  logic [fti_pkg::LOAD_W-1:0]  link_load,
  input  logic [fti_pkg::BW_W-1:0]    link_bandwidth,
  input  fti_pkg::cfg_t               cfg,
  input  fti_pkg::q_stat_t            q_stat,
  output logic                        f_valid,
  output fti_pkg::cls_t               f_cls,
  output logic [FRACTION_BITS-1:0]    f_sup,
  output logic [FRACTION_BITS-1:0]    f_lup
);

  localparam int FB = FRACTION_BITS;
  localparam int SIZE_TAB_N = 2 ** fti_pkg::SIZE_IDX_W;
  localparam int LOAD_TAB_N = 2 ** fti_pkg::LOAD_IDX_W;

  logic [FB-1:0] size_tab [SIZE_TAB_N];
  logic [FB-1:0] load_tab [LOAD_TAB_N];

  for (genvar i = 0; i < SIZE_TAB_N; i++) begin : g_size_tab
    assign size_tab[i] = FB'((64'(i) << FB) / 64'(fti_pkg::SIZE_SPAN));
  end

  for (genvar i = 0; i < LOAD_TAB_N; i++) begin : g_load_tab
    assign load_tab[i] = FB'((64'(i) << FB) / 64'(fti_pkg::LOAD_SPAN));
  end

  logic                        accept;
  logic                        push;
  logic                        f_valid_next;
  fti_pkg::cls_t               cls_next;
  logic [FB-1:0]               sup_next;
  logic [FB-1:0]               lup_next;
  logic [fti_pkg::SIZE_W-1:0]  size_lo_diff;
  logic [fti_pkg::SIZE_W-1:0]  size_hi_diff;
  logic [fti_pkg::LOAD_W-1:0]  load_sat;
  logic [fti_pkg::LOAD_W-1:0]  load_lo_diff;
  logic [fti_pkg::LOAD_W-1:0]  load_hi_diff;

  assign push   = f_valid && !q_stat.full;
  assign busy   = f_valid && q_stat.full;
  assign accept = start && !busy;

  assign size_lo_diff = request_size - fti_pkg::SIZE_B1;
  assign size_hi_diff = request_size - fti_pkg::SIZE_B3;
  assign load_sat     = (link_load > fti_pkg::LOAD_MAX) ? fti_pkg::LOAD_MAX : link_load;
  assign load_lo_diff = load_sat - fti_pkg::LOAD_B1;
  assign load_hi_diff = load_sat - fti_pkg::LOAD_B3;

  always_comb begin
    cls_next.err = (traffic_pattern != fti_pkg::PAT_MS) && (traffic_pattern != fti_pkg::PAT_AA);
    cls_next.aa  = (traffic_pattern == fti_pkg::PAT_AA);

    priority if (request_size <= fti_pkg::SIZE_B1) begin
      cls_next.size_lvl = fti_pkg::LEVEL_LO;
      sup_next          = '0;
    end else if (request_size < fti_pkg::SIZE_B2) begin
      cls_next.size_lvl = fti_pkg::LEVEL_LO;
      sup_next          = size_tab[size_lo_diff[fti_pkg::SIZE_IDX_W-1:0]];
    end else if (request_size <= fti_pkg::SIZE_B3) begin
      cls_next.size_lvl = fti_pkg::LEVEL_MID;
      sup_next          = '0;
    end else if (request_size < fti_pkg::SIZE_B4) begin
      cls_next.size_lvl = fti_pkg::LEVEL_MID;
      sup_next          = size_tab[size_hi_diff[fti_pkg::SIZE_IDX_W-1:0]];
    end else begin
      cls_next.size_lvl = fti_pkg::LEVEL_HI;
      sup_next          = '0;
    end

    priority if (load_sat <= fti_pkg::LOAD_B1) begin
      cls_next.load_lvl = fti_pkg::LEVEL_LO;
      lup_next          = '0;
    end else if (load_sat < fti_pkg::LOAD_B2) begin
      cls_next.load_lvl = fti_pkg::LEVEL_LO;
      lup_next          = load_tab[load_lo_diff[fti_pkg::LOAD_IDX_W-1:0]];
    end else if (load_sat <= fti_pkg::LOAD_B3) begin
      cls_next.load_lvl = fti_pkg::LEVEL_MID;
      lup_next          = '0;
    end else if (load_sat < fti_pkg::LOAD_B4) begin
      cls_next.load_lvl = fti_pkg::LEVEL_MID;
      lup_next          = load_tab[load_hi_diff[fti_pkg::LOAD_IDX_W-1:0]];
    end else begin
      cls_next.load_lvl = fti_pkg::LEVEL_HI;
      lup_next          = '0;
    end

    priority if (link_bandwidth <= cfg.bw_low) begin
      cls_next.band = fti_pkg::LEVEL_LO;
    end else if (link_bandwidth <= cfg.bw_high) begin
      cls_next.band = fti_pkg::LEVEL_MID;
    end else begin
      cls_next.band = fti_pkg::LEVEL_HI;
    end
  end

  always_comb begin
    f_valid_next = f_valid;
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cls <= cls_next;
      f_sup <= sup_next;
      f_lup <= lup_next;
    end
  end

endmodule

// ----- design/fti_queue.sv -----
// Short queue between the classifying front end and the rule back end
module fti_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fti_pkg::q_stat_t stat
);

  localparam int DEPTH = fti_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_FULL);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/fti_cog.sv -----
// Pipelined center-of-gravity divider, one quotient bit per stage
module fti_cog #(
  parameter int FRACTION_BITS = fti_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [fti_pkg::WEIGHT_W+FRACTION_BITS+1:0] s0,
  input  logic [fti_pkg::WEIGHT_W+FRACTION_BITS+1:0] s1,
  input  logic [fti_pkg::WEIGHT_W+FRACTION_BITS+1:0] s2,
  output logic                              out_valid,
  output logic [fti_pkg::RESULT_W-1:0]      quotient
);

  localparam int SW = fti_pkg::WEIGHT_W + FRACTION_BITS + 2;
  localparam int DW = SW + 4;
  localparam int RW = DW + 1;
  localparam int QB = fti_pkg::QUOT_BITS;

  logic [DW-1:0] total;
  logic [DW-1:0] num;
  logic [DW-1:0] den;

  logic [DW-1:0] rem   [QB+1];
  logic [DW-1:0] den_p [QB+1];
  logic [QB-1:0] quo   [QB+1];
  logic          zro   [QB+1];
  logic          vld   [QB+1];

  assign total = DW'(s0) + DW'(s1) + DW'(s2);
  assign num   = DW'(s0) + (DW'(s1) << 2) + DW'(s1) + (DW'(s2) << 3) + DW'(s2);
  assign den   = (total << 3) + (total << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0]   <= num;
    den_p[0] <= den;
    quo[0]   <= '0;
    zro[0]   <= (total == '0);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [RW-1:0] shifted;
    logic          ge;

    assign shifted = {rem[k-1], 1'b0};
    assign ge      = (shifted >= {1'b0, den_p[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[k]   <= ge ? DW'(shifted - {1'b0, den_p[k-1]}) : DW'(shifted);
      den_p[k] <= den_p[k-1];
      quo[k]   <= {quo[k-1][QB-2:0], ge};
      zro[k]   <= zro[k-1];
    end
  end

  assign out_valid = vld[QB];
  assign quotient  = zro[QB] ? '0 : fti_pkg::RESULT_W'(quo[QB]);

endmodule

// ----- design/fti_back.sv -----
// Back end: weighted rule strengths, defuzzification and result strobe
`include "fuzzy_threshold_inference_core_assert.svh"

module fti_back #(
  parameter int FRACTION_BITS = fti_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fti_pkg::q_stat_t               q_stat,
  input  fti_pkg::cls_t                  head_cls,
  input  logic [FRACTION_BITS-1:0]       head_sup,
  input  logic [FRACTION_BITS-1:0]       head_lup,
  input  fti_pkg::cfg_t                  cfg,
  output logic                           pop,
  output logic                           done,
  output logic [fti_pkg::RESULT_W-1:0]   delta_value,
  output logic [fti_pkg::RESULT_W-1:0]   lambda_value,
  output logic                           pattern_error
);

  localparam int FB = FRACTION_BITS;
  localparam int WW = fti_pkg::WEIGHT_W;
  localparam int PW = WW + FB;
  localparam int SW = PW + 2;
  localparam int LAT = fti_pkg::COG_LAT;

  function automatic logic [SW-1:0] lvl_term(input logic [1:0] lvl, input logic [1:0] j,
                                             input logic [PW-1:0] full,
                                             input logic [PW-1:0] part);
    logic [SW-1:0] t;
    t = '0;
    if (lvl == j) begin
      t = SW'(full - part);
    end else if ((lvl + 2'd1) == j) begin
      t = SW'(part);
    end
    return t;
  endfunction

  function automatic logic [SW-1:0] flag_term(input logic f, input logic [WW-1:0] w);
    logic [SW-1:0] t;
    t = f ? SW'({w, {FB{1'b0}}}) : '0;
    return t;
  endfunction

  logic           v1;
  fti_pkg::cls_t  cls1;
  logic [PW-1:0]  p_sd;
  logic [PW-1:0]  p_sl;
  logic [PW-1:0]  p_ll;

  logic           v2;
  logic           err2;
  logic [SW-1:0]  d0, d1, d2;
  logic [SW-1:0]  l0, l1, l2;
  logic [SW-1:0]  d0_next, d1_next, d2_next;
  logic [SW-1:0]  l0_next, l1_next, l2_next;

  logic [PW-1:0]  swd_full;
  logic [PW-1:0]  swl_full;
  logic [PW-1:0]  lwl_full;
  logic           ms1;

  logic           d_valid;
  logic           l_valid;
  logic [fti_pkg::RESULT_W-1:0] d_quo;
  logic [fti_pkg::RESULT_W-1:0] l_quo;
  logic [LAT-1:0] err_line;

  assign pop = !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= pop;
    end
  end

  always_ff @(posedge clk) begin
    cls1 <= head_cls;
    p_sd <= PW'(cfg.size_w_delta) * PW'(head_sup);
    p_sl <= PW'(cfg.size_w_lambda) * PW'(head_sup);
    p_ll <= PW'(cfg.load_w_lambda) * PW'(head_lup);
  end

  assign swd_full = {cfg.size_w_delta, {FB{1'b0}}};
  assign swl_full = {cfg.size_w_lambda, {FB{1'b0}}};
  assign lwl_full = {cfg.load_w_lambda, {FB{1'b0}}};
  assign ms1      = !cls1.err && !cls1.aa;

  always_comb begin
    d0_next = lvl_term(cls1.size_lvl, fti_pkg::LEVEL_LO, swd_full, p_sd)
            + flag_term(ms1, cfg.pat_w_delta);
    d1_next = lvl_term(cls1.size_lvl, fti_pkg::LEVEL_MID, swd_full, p_sd);
    d2_next = lvl_term(cls1.size_lvl, fti_pkg::LEVEL_HI, swd_full, p_sd)
            + flag_term(cls1.aa, cfg.pat_w_delta);

    l0_next = lvl_term(cls1.size_lvl, fti_pkg::LEVEL_HI, swl_full, p_sl)
            + flag_term(cls1.aa, cfg.pat_w_lambda)
            + lvl_term(cls1.load_lvl, fti_pkg::LEVEL_HI, lwl_full, p_ll)
            + flag_term(cls1.band == fti_pkg::LEVEL_LO, cfg.bw_w_lambda);
    l1_next = lvl_term(cls1.size_lvl, fti_pkg::LEVEL_MID, swl_full, p_sl)
            + lvl_term(cls1.load_lvl, fti_pkg::LEVEL_MID, lwl_full, p_ll)
            + flag_term(cls1.band == fti_pkg::LEVEL_MID, cfg.bw_w_lambda);
    l2_next = lvl_term(cls1.size_lvl, fti_pkg::LEVEL_LO, swl_full, p_sl)
            + flag_term(ms1, cfg.pat_w_lambda)
            + lvl_term(cls1.load_lvl, fti_pkg::LEVEL_LO, lwl_full, p_ll)
            + flag_term(cls1.band == fti_pkg::LEVEL_HI, cfg.bw_w_lambda);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    err2 <= cls1.err;
    d0   <= d0_next;
    d1   <= d1_next;
    d2   <= d2_next;
    l0   <= l0_next;
    l1   <= l1_next;
    l2   <= l2_next;
  end

  fti_cog #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_cog_delta (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .s0       (d0),
    .s1       (d1),
    .s2       (d2),
    .out_valid(d_valid),
    .quotient (d_quo)
  );

  fti_cog #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_cog_lambda (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .s0       (l0),
    .s1       (l1),
    .s2       (l2),
    .out_valid(l_valid),
    .quotient (l_quo)
  );

  always_ff @(posedge clk) begin
    err_line <= {err_line[LAT-2:0], err2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    pattern_error <= err_line[LAT-1];
    delta_value   <= err_line[LAT-1] ? '0 : d_quo;
    lambda_value  <= err_line[LAT-1] ? '0 : l_quo;
  end

  `FTI_ASSERT_ALWAYS(a_cog_aligned, clk, rst, d_valid == l_valid)
  `FTI_ASSERT_IMPLY(a_error_zero, clk, rst, done && pattern_error, delta_value == '0 && lambda_value == '0)
  `FTI_ASSERT_IMPLY(a_delta_range, clk, rst, done, delta_value <= fti_pkg::COG_MAX)
  `FTI_ASSERT_IMPLY(a_lambda_range, clk, rst, done, lambda_value <= fti_pkg::COG_MAX)
  `FTI_ASSERT_NEXT(a_pop_reaches_div, clk, rst, v1, v2)

endmodule

// ----- design/fuzzy_threshold_inference_core.sv -----
// Top level: configuration registers, front end, queue and back end of the fuzzy core
// Path to done: front-end register, queue, back-end stages v1 and v2, divider pipeline, done register.
// Throughput: one request per cycle while busy is low; the back end pops the queue whenever it is not empty.
// The longest part of that path is the 16-stage quotient pipeline of the center-of-gravity dividers.
// Reset (rst, synchronous): clears all valid flags and the queue, loads register defaults.
// Config writes are taken every cycle (cfg_ready high); results cannot be held off.
module fuzzy_threshold_inference_core #(
  parameter int FRACTION_BITS = fti_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [fti_pkg::SIZE_W-1:0]     request_size,
  input  logic [fti_pkg::PAT_W-1:0]      traffic_pattern,
  input  logic [fti_pkg::LOAD_W-1:0]     link_load,
  input  logic [fti_pkg::BW_W-1:0]       link_bandwidth,
  output logic                           done,
  output logic [fti_pkg::RESULT_W-1:0]   delta_value,
  output logic [fti_pkg::RESULT_W-1:0]   lambda_value,
  output logic                           pattern_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fti_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int FB    = FRACTION_BITS;
  localparam int CLS_W = $bits(fti_pkg::cls_t);
  localparam int QW    = CLS_W + 2 * FB;

  fti_pkg::cfg_t    cfg;
  fti_pkg::q_stat_t q_stat;
  fti_pkg::cls_t    f_cls;
  fti_pkg::cls_t    head_cls;
  logic             f_valid;
  logic [FB-1:0]    f_sup;
  logic [FB-1:0]    f_lup;
  logic [FB-1:0]    head_sup;
  logic [FB-1:0]    head_lup;
  logic [QW-1:0]    q_wdata;
  logic [QW-1:0]    q_rdata;
  logic             q_push;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_w_delta  <= fti_pkg::RST_SIZE_W_DELTA;
      cfg.pat_w_delta   <= fti_pkg::RST_PAT_W_DELTA;
      cfg.size_w_lambda <= fti_pkg::RST_SIZE_W_LAMBDA;
      cfg.pat_w_lambda  <= fti_pkg::RST_PAT_W_LAMBDA;
      cfg.load_w_lambda <= fti_pkg::RST_LOAD_W_LAMBDA;
      cfg.bw_w_lambda   <= fti_pkg::RST_BW_W_LAMBDA;
      cfg.bw_low        <= fti_pkg::RST_BW_LOW;
      cfg.bw_high       <= fti_pkg::RST_BW_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fti_pkg::REG_SIZE_W_DELTA:  cfg.size_w_delta  <= cfg_data[fti_pkg::WEIGHT_W-1:0];
        fti_pkg::REG_PAT_W_DELTA:   cfg.pat_w_delta   <= cfg_data[fti_pkg::WEIGHT_W-1:0];
        fti_pkg::REG_SIZE_W_LAMBDA: cfg.size_w_lambda <= cfg_data[fti_pkg::WEIGHT_W-1:0];
        fti_pkg::REG_PAT_W_LAMBDA:  cfg.pat_w_lambda  <= cfg_data[fti_pkg::WEIGHT_W-1:0];
        fti_pkg::REG_LOAD_W_LAMBDA: cfg.load_w_lambda <= cfg_data[fti_pkg::WEIGHT_W-1:0];
        fti_pkg::REG_BW_W_LAMBDA:   cfg.bw_w_lambda   <= cfg_data[fti_pkg::WEIGHT_W-1:0];
        fti_pkg::REG_BW_LOW:        cfg.bw_low        <= cfg_data[fti_pkg::LIMIT_W-1:0];
        fti_pkg::REG_BW_HIGH:       cfg.bw_high       <= cfg_data[fti_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  fti_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request_size   (request_size),
    .traffic_pattern(traffic_pattern),
    .link_load      (link_load),
    .link_bandwidth (link_bandwidth),
    .cfg            (cfg),
    .q_stat         (q_stat),
    .f_valid        (f_valid),
    .f_cls          (f_cls),
    .f_sup          (f_sup),
    .f_lup          (f_lup)
  );

  assign q_push  = f_valid;
  assign q_wdata = {f_cls, f_sup, f_lup};

  fti_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  assign head_cls = q_rdata[QW-1 -: CLS_W];
  assign head_sup = q_rdata[2*FB-1 -: FB];
  assign head_lup = q_rdata[FB-1:0];

  fti_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head_cls     (head_cls),
    .head_sup     (head_sup),
    .head_lup     (head_lup),
    .cfg          (cfg),
    .pop          (q_pop),
    .done         (done),
    .delta_value  (delta_value),
    .lambda_value (lambda_value),
    .pattern_error(pattern_error)
  );

endmodule
